/* sv/modinv_pkg.sv */
// modinv_pkg: shared constants and control types for the modular inverse block
// used by modinv_divider and modular_inverse_extended_gcd; no dependencies
package modinv_pkg;

  // default operand width
  localparam int OPERAND_BITS_DEF = 32;

  // command from the sequencer to the serial divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

  // status from the serial divider back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* sv/modinv_divider.sv */
// modinv_divider: restoring serial divider, one quotient bit a cycle, which also
// accumulates quotient times a signed coefficient by shift and add
// depends on modinv_pkg
module modinv_divider #(
  parameter int OPERAND_BITS = modinv_pkg::OPERAND_BITS_DEF,
  parameter int COEF_BITS    = OPERAND_BITS + 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  modinv_pkg::div_ctl_t   ctl,
  input  logic [OPERAND_BITS-1:0] dividend,
  input  logic [OPERAND_BITS-1:0] divisor,
  input  logic [COEF_BITS-1:0]    coef,
  output modinv_pkg::div_stat_t  stat,
  output logic [OPERAND_BITS-1:0] remainder,
  output logic [COEF_BITS-1:0]    product
);
  import modinv_pkg::*;

  localparam int W        = OPERAND_BITS;
  localparam int CNT_BITS = $clog2(W);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(W - 1);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]        rem_r, rem_nxt;
  logic [W-1:0]        dvd_r, dvd_nxt;
  logic [W-1:0]        dvs_r, dvs_nxt;
  logic [COEF_BITS-1:0] coef_r, coef_nxt;
  logic [COEF_BITS-1:0] acc_r, acc_nxt;

  logic [W:0] shifted;
  logic [W:0] dvs_ext;
  logic [W:0] diff;
  logic       ge;

  // one restoring step: shift in the next dividend bit, trial subtract
  always_comb begin
    shifted = {rem_r, dvd_r[W-1]};
    dvs_ext = {1'b0, dvs_r};
    diff    = shifted - dvs_ext;
    ge      = (shifted >= dvs_ext);
  end

  // step sequencing and datapath updates
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    coef_nxt = coef_r;
    acc_nxt  = acc_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      coef_nxt = coef;
      acc_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      acc_nxt = {acc_r[COEF_BITS-2:0], 1'b0} + (ge ? coef_r : '0);
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    dvs_r  <= dvs_nxt;
    coef_r <= coef_nxt;
    acc_r  <= acc_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;
  assign product   = acc_r;

endmodule

/* sv/modular_inverse_extended_gcd.sv */
// modular_inverse_extended_gcd: top level, sequencer for the extended Euclidean
// algorithm around one shared serial divider, plus the result register
// depends on modinv_pkg and modinv_divider
//
// Usage:
//   in channel  (in_tvalid/in_tready/in_tdata): one transfer per item carrying
//     value and modulus. in_tready is high only while the block is idle.
//   out channel (out_tvalid/out_tready/out_tdata/out_tuser): one transfer per
//     item carrying the inverse, the gcd and the no_inverse flag.
//   Sequence: the value is first reduced modulo the modulus on the divider;
//     then every Euclid iteration takes the start of the serial divider (one
//     quotient bit a cycle), the division and the update, and once the
//     remainder is zero the final check, normalisation and output load
//     follow. A zero modulus skips the divider and goes to the output load.
//   Throughput: one item at a time; the next transfer is taken once the
//     previous result has been placed in the output register.
//   Reset: rst_n low clears the sequencer and the output valid; nothing to
//     clear in the datapath.
//   Stall: a result waits in the output register while out_tready is low; a
//     finished item behind it waits in the sequencer until that register frees.
module modular_inverse_extended_gcd #(
  parameter int OPERAND_BITS = modinv_pkg::OPERAND_BITS_DEF,
  localparam int DATA_BITS   = ((2 * OPERAND_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [DATA_BITS-1:0] in_tdata,   // value, modulus, zero padding
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_BITS-1:0] out_tdata,  // inverse, gcd, zero padding
  output logic                 out_tuser   // no_inverse
);
  import modinv_pkg::*;

  localparam int W  = OPERAND_BITS;
  localparam int CW = OPERAND_BITS + 2;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_DIVIDE = 3'd3;
  localparam logic [2:0] S_FIX    = 3'd4;
  localparam logic [2:0] S_HOLD   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [W-1:0] r0_r, r0_nxt;
  logic [W-1:0] r1_r, r1_nxt;
  logic [CW-1:0] c0_r, c0_nxt;
  logic [CW-1:0] c1_r, c1_nxt;
  logic [W-1:0] mod_r, mod_nxt;
  logic [W-1:0] res_inv_r, res_inv_nxt;
  logic [W-1:0] res_gcd_r, res_gcd_nxt;
  logic         res_none_r, res_none_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] out_inv_r, out_inv_nxt;
  logic [W-1:0] out_gcd_r, out_gcd_nxt;
  logic         out_none_r, out_none_nxt;

  div_ctl_t  dctl;
  div_stat_t dstat;
  logic [W-1:0]  div_dividend;
  logic [W-1:0]  div_divisor;
  logic [CW-1:0] div_coef;
  logic [W-1:0]  div_rem;
  logic [CW-1:0] div_prod;

  logic [W-1:0]  in_value;
  logic [W-1:0]  in_modulus;
  logic          in_xfer;
  logic          out_load;
  logic [CW-1:0] mod_ext;
  logic [CW-1:0] inv_norm;

  assign in_value   = in_tdata[W-1:0];
  assign in_modulus = in_tdata[2*W-1:W];
  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_load   = (state_r == S_HOLD) && (!out_valid_r || out_tready);

  // shared serial divider
  modinv_divider #(
    .OPERAND_BITS(OPERAND_BITS),
    .COEF_BITS   (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .coef     (div_coef),
    .stat     (dstat),
    .remainder(div_rem),
    .product  (div_prod)
  );

  // normalise the final coefficient into 0 .. modulus-1
  always_comb begin
    mod_ext = {2'b00, mod_r};
    if (c0_r[CW-1]) begin
      inv_norm = c0_r + mod_ext;
    end else if (c0_r >= mod_ext) begin
      inv_norm = c0_r - mod_ext;
    end else begin
      inv_norm = c0_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    r0_nxt       = r0_r;
    r1_nxt       = r1_r;
    c0_nxt       = c0_r;
    c1_nxt       = c1_r;
    mod_nxt      = mod_r;
    res_inv_nxt  = res_inv_r;
    res_gcd_nxt  = res_gcd_r;
    res_none_nxt = res_none_r;
    dctl.start   = 1'b0;
    div_dividend = r0_r;
    div_divisor  = r1_r;
    div_coef     = c1_r;
    unique case (state_r)
      S_IDLE: begin
        div_dividend = in_value;
        div_divisor  = in_modulus;
        if (in_xfer) begin
          mod_nxt = in_modulus;
          if (in_modulus == '0) begin
            // no reduction possible: gcd is the value itself
            res_inv_nxt  = '0;
            res_gcd_nxt  = in_value;
            res_none_nxt = 1'b1;
            state_nxt    = S_HOLD;
          end else begin
            dctl.start = 1'b1;
            state_nxt  = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (dstat.done) begin
          r0_nxt    = div_rem;
          r1_nxt    = mod_r;
          c0_nxt    = CW'(1);
          c1_nxt    = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (r1_r == '0) begin
          state_nxt = S_FIX;
        end else begin
          dctl.start = 1'b1;
          state_nxt  = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (dstat.done) begin
          r0_nxt    = r1_r;
          r1_nxt    = div_rem;
          c0_nxt    = c1_r;
          c1_nxt    = c0_r - div_prod;
          state_nxt = S_CHECK;
        end
      end
      S_FIX: begin
        res_gcd_nxt  = r0_r;
        res_none_nxt = (r0_r != W'(1));
        res_inv_nxt  = (r0_r != W'(1)) ? '0 : inv_norm[W-1:0];
        state_nxt    = S_HOLD;
      end
      S_HOLD: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_inv_nxt   = out_inv_r;
    out_gcd_nxt   = out_gcd_r;
    out_none_nxt  = out_none_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_inv_nxt   = res_inv_r;
      out_gcd_nxt   = res_gcd_r;
      out_none_nxt  = res_none_r;
    end else if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    r0_r       <= r0_nxt;
    r1_r       <= r1_nxt;
    c0_r       <= c0_nxt;
    c1_r       <= c1_nxt;
    mod_r      <= mod_nxt;
    res_inv_r  <= res_inv_nxt;
    res_gcd_r  <= res_gcd_nxt;
    res_none_r <= res_none_nxt;
    out_inv_r  <= out_inv_nxt;
    out_gcd_r  <= out_gcd_nxt;
    out_none_r <= out_none_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_BITS'({out_gcd_r, out_inv_r});
  assign out_tuser  = out_none_r;

endmodule
